// File: rtl/fnif_pkg.sv
package fnif_pkg;

    // Fixed field widths of the ports
    localparam int PIX_IN_W   = 8;
    localparam int PIX_OUT_W  = 8;
    localparam int ROW_OUT_W  = 10;
    localparam int COL_OUT_W  = 5;

    // Configuration register widths
    localparam int THR_W      = 8;
    localparam int WID_W      = 6;
    localparam int HGT_W      = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    // Compare domains wide enough for any legal column / row limit
    localparam int W_CMP_W    = 7;
    localparam int H_CMP_W    = 17;

    // Reset values of the configuration registers
    localparam logic [THR_W-1:0] THR_RST = 8'd1;
    localparam logic [WID_W-1:0] WID_RST = 6'd32;
    localparam logic [HGT_W-1:0] HGT_RST = 11'd32;

    // Neighbor slots of the judge unit
    localparam int NB_MAX     = 4;
    localparam int NB_CNT_W   = 3;
    localparam int NB_UP      = 0;
    localparam int NB_LEFT    = 1;
    localparam int NB_DOWN    = 2;
    localparam int NB_RIGHT   = 3;

    // Register indexes of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD = 2'd0,
        CFG_WIDTH     = 2'd1,
        CFG_HEIGHT    = 2'd2
    } t_cfg_idx;

    // Input request payload
    typedef struct packed {
        logic [PIX_IN_W-1:0] pixel_in;
    } t_pix_req;

    // Result request payload
    typedef struct packed {
        logic [PIX_OUT_W-1:0] pixel_out;
        logic [ROW_OUT_W-1:0] out_row;
        logic [COL_OUT_W-1:0] out_col;
        logic                 was_replaced;
        logic                 last_of_run;
        logic                 end_of_image;
    } t_res_req;

endpackage

// File: rtl/fnif_intf.sv
// Pixel input channel
interface fnif_pix_if;
    import fnif_pkg::*;
    logic     valid;
    logic     ready;
    t_pix_req data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

// Filtered result channel
interface fnif_res_if;
    import fnif_pkg::*;
    logic     valid;
    logic     ready;
    t_res_req data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

// File: rtl/four_neighbor_impulse_filter.sv
// Four-neighbor impulse noise filter, pixels in raster order.
// i_pix carries one pixel per request (valid/ready). o_res carries one
// filtered pixel per request with its row, column, a replaced flag, a flag
// on the last result of each input and a flag on the image's last pixel.
// The configuration port (i_cfg_we, i_cfg_idx, i_cfg_data) sets threshold,
// width and height; write it only while the block is idle.
// Pixels of the first row are only stored, with no result.
// Every later pixel releases the pixel above it in the steps accept,
// memory read and compare, divide and write back, set by the
// read-modify-write of the row memories. The last pixel of the image then
// flushes the final row one pixel at a time, as the left neighbor of
// each pixel is the filtered value of the one before.
// Results sit in an output register; a new pixel is taken while one waits,
// and a stalled receiver holds the block in its write-back step.
// Reset (synchronous, active low) restores the register defaults and the
// raster position; row memory contents are not cleared.
module four_neighbor_impulse_filter #(
    parameter int MAX_COLS   = 32,
    parameter int MAX_ROWS   = 1024,
    parameter int PIXEL_BITS = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    fnif_pix_if.sink                        i_pix,
    fnif_res_if.source                      o_res,
    input  logic                            i_cfg_we,
    input  logic [fnif_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [fnif_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import fnif_pkg::*;

    localparam int AW = $clog2(MAX_COLS);
    localparam int RW = $clog2(MAX_ROWS);
    localparam logic [W_CMP_W-1:0] MAXC = W_CMP_W'(MAX_COLS);
    localparam logic [H_CMP_W-1:0] MAXR = H_CMP_W'(MAX_ROWS);
    localparam logic [W_CMP_W-1:0] MINW = W_CMP_W'(2);
    localparam logic [H_CMP_W-1:0] MINH = H_CMP_W'(2);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EVAL = 3'b010,
        S_EMIT = 3'b100
    } t_state;

    t_state                r_state;
    logic [THR_W-1:0]      r_thr;
    logic [WID_W-1:0]      r_wid;
    logic [HGT_W-1:0]      r_hgt;
    logic [AW-1:0]         r_col;
    logic [RW-1:0]         r_row;
    logic [AW-1:0]         r_cur_c;
    logic [RW-1:0]         r_item_row;
    logic [PIXEL_BITS-1:0] r_p;
    logic                  r_has_above;
    logic                  r_flush_pend;
    logic                  r_flush;
    logic [AW-1:0]         r_fj;
    logic [PIXEL_BITS-1:0] r_left;
    logic                  r_out_valid;
    t_res_req              r_out;

    logic [W_CMP_W-1:0]    wv;
    logic [W_CMP_W-1:0]    eff_w;
    logic [H_CMP_W-1:0]    hv;
    logic [H_CMP_W-1:0]    eff_h;
    logic                  last_col;
    logic                  last_row;
    logic                  in_acc;
    logic [PIXEL_BITS-1:0] p_in;
    logic [AW-1:0]         rd_col;
    logic [AW-1:0]         rd_nxt;
    logic [AW-1:0]         cc;
    logic                  fj_last;
    logic                  emit_go;

    logic [PIXEL_BITS-1:0] p_rd0;
    logic [PIXEL_BITS-1:0] p_rd1;
    logic [PIXEL_BITS-1:0] a_rd;
    logic [PIXEL_BITS-1:0] nb [NB_MAX];
    logic [NB_MAX-1:0]     present;
    logic [PIXEL_BITS-1:0] j_value;
    logic                  j_replaced;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RST;
            r_wid <= WID_RST;
            r_hgt <= HGT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_THRESHOLD: r_thr <= i_cfg_data[THR_W-1:0];
                CFG_WIDTH:     r_wid <= i_cfg_data[WID_W-1:0];
                CFG_HEIGHT:    r_hgt <= i_cfg_data[HGT_W-1:0];
                default:       ;
            endcase
        end
    end

    // Clamped image dimensions
    always_comb begin
        wv = W_CMP_W'(r_wid);
        hv = H_CMP_W'(r_hgt);
        if (wv < MINW) begin
            eff_w = MINW;
        end else if (wv > MAXC) begin
            eff_w = MAXC;
        end else begin
            eff_w = wv;
        end
        if (hv < MINH) begin
            eff_h = MINH;
        end else if (hv > MAXR) begin
            eff_h = MAXR;
        end else begin
            eff_h = hv;
        end
    end

    assign last_col = (W_CMP_W'(r_col) + W_CMP_W'(1)) >= eff_w;
    assign last_row = (H_CMP_W'(r_row) + H_CMP_W'(1)) >= eff_h;

    assign i_pix.ready = (r_state == S_IDLE);
    assign in_acc      = i_pix.valid && i_pix.ready;
    assign p_in        = PIXEL_BITS'(i_pix.data.pixel_in);

    // Column under work and flush end test
    assign cc      = r_flush ? r_fj : r_cur_c;
    assign fj_last = (W_CMP_W'(r_fj) + W_CMP_W'(1)) >= eff_w;
    assign emit_go = (r_state == S_EMIT) && (!r_out_valid || o_res.ready);

    // Read address: the new pixel's column at accept, the next flush column
    // at write-back; the right neighbor sits one column on
    always_comb begin
        case (r_state)
            S_IDLE:  rd_col = r_col;
            S_EMIT:  rd_col = r_flush ? (r_fj + AW'(1)) : '0;
            default: rd_col = r_cur_c;
        endcase
        if ((32'(rd_col) + 32'd1) < 32'(MAX_COLS)) begin
            rd_nxt = rd_col + AW'(1);
        end else begin
            rd_nxt = '0;
        end
    end

    fnif_store #(
        .DEPTH (MAX_COLS),
        .AW    (AW),
        .PW    (PIXEL_BITS)
    ) u_store (
        .i_clk      (i_clk),
        .i_p_we     (in_acc),
        .i_p_waddr  (r_col),
        .i_p_wdata  (p_in),
        .i_p_raddr0 (rd_col),
        .i_p_raddr1 (rd_nxt),
        .o_p_rdata0 (p_rd0),
        .o_p_rdata1 (p_rd1),
        .i_a_we     (emit_go),
        .i_a_waddr  (cc),
        .i_a_wdata  (j_value),
        .i_a_raddr  (rd_col),
        .o_a_rdata  (a_rd)
    );

    // Neighbor set: up and left are filtered, down and right are raw
    always_comb begin
        nb[NB_UP]         = a_rd;
        nb[NB_LEFT]       = r_left;
        nb[NB_DOWN]       = r_p;
        nb[NB_RIGHT]      = p_rd1;
        present[NB_UP]    = r_flush || r_has_above;
        present[NB_LEFT]  = (cc != '0);
        present[NB_DOWN]  = !r_flush;
        present[NB_RIGHT] = (W_CMP_W'(cc) + W_CMP_W'(1)) < eff_w;
    end

    fnif_judge #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_judge (
        .i_clk      (i_clk),
        .i_load     (r_state == S_EVAL),
        .i_thr      (r_thr),
        .i_center   (p_rd0),
        .i_nb       (nb),
        .i_present  (present),
        .o_value    (j_value),
        .o_replaced (j_replaced)
    );

    // Sequencer, raster position and flush walk
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_col        <= '0;
            r_row        <= '0;
            r_flush      <= 1'b0;
            r_flush_pend <= 1'b0;
            r_fj         <= '0;
            r_left       <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_flush_pend <= last_col && last_row;
                        if (last_col) begin
                            r_col <= '0;
                            r_row <= last_row ? '0 : (r_row + RW'(1));
                        end else begin
                            r_col <= r_col + AW'(1);
                        end
                        r_state <= (r_row != '0) ? S_EVAL : S_IDLE;
                    end
                end
                S_EVAL: begin
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (emit_go) begin
                        r_left <= j_value;
                        if (!r_flush && r_flush_pend) begin
                            r_flush <= 1'b1;
                            r_fj    <= '0;
                            r_state <= S_EVAL;
                        end else if (r_flush && !fj_last) begin
                            r_fj    <= r_fj + AW'(1);
                            r_state <= S_EVAL;
                        end else begin
                            r_flush <= 1'b0;
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Per-item context
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cur_c     <= r_col;
            r_item_row  <= r_row;
            r_p         <= p_in;
            r_has_above <= r_row > RW'(1);
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit_go) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_go) begin
            r_out.pixel_out    <= PIX_OUT_W'(j_value);
            r_out.out_row      <= ROW_OUT_W'(r_flush ? r_item_row : (r_item_row - RW'(1)));
            r_out.out_col      <= COL_OUT_W'(cc);
            r_out.was_replaced <= j_replaced;
            r_out.last_of_run  <= r_flush ? fj_last : !r_flush_pend;
            r_out.end_of_image <= r_flush && fj_last;
        end
    end

    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

    // A pixel below the first row always goes on to the memory read
    ast_eval_after_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (r_row != '0) |=> r_state == S_EVAL)
        else $error("accepted pixel did not start evaluation");

    // The flush walk never passes the row end
    ast_flush_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_flush |-> (W_CMP_W'(r_fj) < eff_w))
        else $error("flush column beyond image width");

    // End of image only ever marks the last result of its input
    ast_eoi_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.end_of_image |-> r_out.last_of_run)
        else $error("end of image without last of run");

    // A stalled write-back holds its place in the flush walk
    ast_emit_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) && !emit_go |=> (r_state == S_EMIT) && $stable(r_fj))
        else $error("write-back advanced while output stalled");

endmodule

// File: rtl/fnif_store.sv
// Row stores: raw pending row (two read ports) and filtered row above
// (one read port). Read data registered, old data on a same-address write.
module fnif_store #(
    parameter int DEPTH = 32,
    parameter int AW    = 5,
    parameter int PW    = 8
) (
    input  logic          i_clk,
    input  logic          i_p_we,
    input  logic [AW-1:0] i_p_waddr,
    input  logic [PW-1:0] i_p_wdata,
    input  logic [AW-1:0] i_p_raddr0,
    input  logic [AW-1:0] i_p_raddr1,
    output logic [PW-1:0] o_p_rdata0,
    output logic [PW-1:0] o_p_rdata1,
    input  logic          i_a_we,
    input  logic [AW-1:0] i_a_waddr,
    input  logic [PW-1:0] i_a_wdata,
    input  logic [AW-1:0] i_a_raddr,
    output logic [PW-1:0] o_a_rdata
);

    logic [PW-1:0] r_pend_mem  [DEPTH];
    logic [PW-1:0] r_above_mem [DEPTH];
    logic [PW-1:0] r_p_rd0;
    logic [PW-1:0] r_p_rd1;
    logic [PW-1:0] r_a_rd;

    // Pending raw row
    always_ff @(posedge i_clk) begin
        if (i_p_we) begin
            r_pend_mem[i_p_waddr] <= i_p_wdata;
        end
        r_p_rd0 <= r_pend_mem[i_p_raddr0];
        r_p_rd1 <= r_pend_mem[i_p_raddr1];
    end

    // Filtered row above
    always_ff @(posedge i_clk) begin
        if (i_a_we) begin
            r_above_mem[i_a_waddr] <= i_a_wdata;
        end
        r_a_rd <= r_above_mem[i_a_raddr];
    end

    assign o_p_rdata0 = r_p_rd0;
    assign o_p_rdata1 = r_p_rd1;
    assign o_a_rdata  = r_a_rd;

endmodule

// File: rtl/fnif_judge.sv
// Impulse judge: stage one compares against the neighbors and sums them,
// stage two divides the sum by the neighbor count and rounds.
module fnif_judge #(
    parameter int PIXEL_BITS = 8
) (
    input  logic                         i_clk,
    input  logic                         i_load,
    input  logic [fnif_pkg::THR_W-1:0]   i_thr,
    input  logic [PIXEL_BITS-1:0]        i_center,
    input  logic [PIXEL_BITS-1:0]        i_nb [fnif_pkg::NB_MAX],
    input  logic [fnif_pkg::NB_MAX-1:0]  i_present,
    output logic [PIXEL_BITS-1:0]        o_value,
    output logic                         o_replaced
);
    import fnif_pkg::*;

    localparam int SW = PIXEL_BITS + 2;
    localparam int DW = (PIXEL_BITS > THR_W) ? PIXEL_BITS : THR_W;
    // floor(2^SW / 3): estimate is exact or one low for any SW-bit sum
    localparam logic [SW-1:0] K3    = SW'((2 ** SW) / 3);
    localparam logic [SW-1:0] THREE = SW'(3);
    localparam logic [SW-1:0] TWO   = SW'(2);

    logic [PIXEL_BITS-1:0] diff [NB_MAX];
    logic                  n_imp;
    logic [SW-1:0]         n_sum;
    logic [NB_CNT_W-1:0]   n_cnt;

    logic [PIXEL_BITS-1:0] r_center;
    logic [SW-1:0]         r_sum;
    logic [NB_CNT_W-1:0]   r_cnt;
    logic                  r_imp;

    logic [2*SW-1:0]       prod3;
    logic [SW-1:0]         q3;
    logic [SW-1:0]         rem3;
    logic [SW-1:0]         q3c;
    logic [SW-1:0]         rem3c;
    logic [SW-1:0]         q_fin;

    // Compare and accumulate over the neighbors that exist
    always_comb begin
        n_imp = 1'b1;
        n_sum = '0;
        n_cnt = '0;
        for (int k = 0; k < NB_MAX; k++) begin
            diff[k] = (i_center > i_nb[k]) ? (i_center - i_nb[k]) : (i_nb[k] - i_center);
            if (i_present[k]) begin
                if (DW'(diff[k]) <= DW'(i_thr)) begin
                    n_imp = 1'b0;
                end
                n_sum = n_sum + SW'(i_nb[k]);
                n_cnt = n_cnt + NB_CNT_W'(1);
            end
        end
    end

    // Stage register
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_center <= i_center;
            r_sum    <= n_sum;
            r_cnt    <= n_cnt;
            r_imp    <= n_imp;
        end
    end

    // Divide by three: reciprocal estimate, then one correction step
    always_comb begin
        prod3 = r_sum * K3;
        q3    = prod3[2*SW-1:SW];
        rem3  = r_sum - (q3 + (q3 << 1));
        if (rem3 >= THREE) begin
            q3c   = q3 + SW'(1);
            rem3c = rem3 - THREE;
        end else begin
            q3c   = q3;
            rem3c = rem3;
        end
    end

    // Round up only when the fraction is above one half
    always_comb begin
        case (r_cnt)
            NB_CNT_W'(2): q_fin = r_sum >> 1;
            NB_CNT_W'(3): q_fin = q3c + SW'(rem3c == TWO);
            NB_CNT_W'(4): q_fin = (r_sum >> 2) + SW'(r_sum[1:0] == 2'b11);
            default:      q_fin = SW'(r_center);
        endcase
    end

    assign o_value    = r_imp ? q_fin[PIXEL_BITS-1:0] : r_center;
    assign o_replaced = r_imp;

endmodule
